@@ hw/rtl/i2c_mbc_pkg.sv @@
// Shared types and constants of the I2C master byte controller.
package i2c_mbc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 10;
  localparam int unsigned BitIdxW  = 4;

  localparam logic [BitIdxW-1:0] BitsPerByte  = 4'd8;
  localparam logic [ByteW-1:0]   TickSat      = 8'hFF;
  localparam logic [ByteW-1:0]   SetupReset   = 8'd4;
  localparam logic [ByteW-1:0]   HalfBitReset = 8'd2;
  localparam logic [TimeoutW-1:0] TimeoutReset = 10'd250;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETUP_TICKS    = 2'd0,
    CFG_HALF_BIT_TICKS = 2'd1,
    CFG_ACK_TIMEOUT    = 2'd2
  } cfg_idx_e;

  // Command codes
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_WAIT_ACK = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  // Bus phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_SP_A  = 4'd3,
    PH_SP_B  = 4'd4,
    PH_SP_C  = 4'd5,
    PH_WR_LO = 4'd6,
    PH_WR_HI = 4'd7,
    PH_WR_TL = 4'd8,
    PH_WA_LO = 4'd9,
    PH_WA_HI = 4'd10,
    PH_RD_LO = 4'd11,
    PH_RD_HI = 4'd12,
    PH_AK_LO = 4'd13,
    PH_AK_HI = 4'd14
  } phase_e;

  // One result transaction
  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             sda_enable;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_error;
  } res_t;

endpackage

@@ hw/rtl/i2c_master_byte_controller.sv @@
// Top level of the I2C master byte controller: bus sequencer and result buffer.
//
// Each input transaction is one timing tick, taken one per clock cycle while
// input stall is low. A tick is worked through in the cycle it is accepted: the
// phase sequencer state is updated and the result is registered into the output
// entry of a two-entry buffer, or its skid entry if that is held. Input stall
// rises only when both entries hold results not yet taken downstream. Phase
// lengths come from setup_ticks, half_bit_ticks and ack_timeout, set via the
// always-ready cfg port; the user must write them only while idle, unenforced.
module i2c_master_byte_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_valid_i,
  input  logic [2:0]                        op_i,
  input  logic [i2c_mbc_pkg::ByteW-1:0]     tx_byte_i,
  input  logic                              send_ack_i,
  input  logic                              sda_in_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              scl_level_o,
  output logic                              sda_level_o,
  output logic                              sda_enable_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [i2c_mbc_pkg::ByteW-1:0]     rx_byte_o,
  output logic                              ack_error_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i2c_mbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [i2c_mbc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i2c_mbc_pkg::*;

  // configuration registers
  logic [ByteW-1:0]    setup_q, half_q;
  logic [TimeoutW-1:0] tmo_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    tick_q, tick_d;
  logic [BitIdxW-1:0]  bit_q, bit_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [TimeoutW-1:0] wait_q, wait_d;
  logic                ack_q, ack_d;
  logic                err_q, err_d;
  logic [ByteW-1:0]    rx_q, rx_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                oe_q, oe_d;
  logic                done_d;

  // tick timing helpers
  logic [ByteW-1:0]    tick_inc;
  logic [ByteW-1:0]    setup_len, half_len;
  logic                exp_setup, exp_half;
  logic [BitIdxW-1:0]  bit_inc;

  // output buffer
  res_t                res_d, out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                in_acc, out_take;

  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  // Accept configuration writes in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= SetupReset;
      half_q  <= HalfBitReset;
      tmo_q   <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SETUP_TICKS:    setup_q <= cfg_data_i[ByteW-1:0];
        CFG_HALF_BIT_TICKS: half_q  <= cfg_data_i[ByteW-1:0];
        CFG_ACK_TIMEOUT:    tmo_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Count ticks within a phase, saturating; a zero length acts as one
  assign tick_inc  = (tick_q < TickSat) ? tick_q + 8'd1 : tick_q;
  assign setup_len = (setup_q == '0) ? 8'd1 : setup_q;
  assign half_len  = (half_q == '0) ? 8'd1 : half_q;
  assign exp_setup = tick_inc >= setup_len;
  assign exp_half  = tick_inc >= half_len;
  assign bit_inc   = bit_q + 4'd1;

  // Next phase, line levels and result for this tick
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    ack_d   = ack_q;
    err_d   = err_q;
    rx_d    = rx_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    oe_d    = oe_q;
    done_d  = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (cmd_valid_i) begin
          case (op_i)
            OP_START: begin
              phase_d = PH_ST_A; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1; tick_d = '0;
            end
            OP_STOP: begin
              phase_d = PH_SP_A; scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1; tick_d = '0;
            end
            OP_WRITE: begin
              shift_d = tx_byte_i;
              bit_d   = '0;
              phase_d = PH_WR_LO; scl_d = 1'b0; sda_d = tx_byte_i[ByteW-1];
              oe_d    = 1'b1; tick_d = '0;
            end
            OP_WAIT_ACK: begin
              phase_d = PH_WA_LO; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0; tick_d = '0;
            end
            OP_READ: begin
              ack_d   = send_ack_i;
              shift_d = '0;
              bit_d   = '0;
              phase_d = PH_RD_LO; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0; tick_d = '0;
            end
            default: ;
          endcase
        end
      end
      PH_ST_A: begin
        tick_d = tick_inc;
        if (exp_setup) begin
          phase_d = PH_ST_B; scl_d = 1'b1; sda_d = 1'b0; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_ST_B: begin
        tick_d = tick_inc;
        if (exp_setup) begin
          scl_d = 1'b0; phase_d = PH_IDLE; tick_d = '0; done_d = 1'b1;
        end
      end
      PH_SP_A: begin
        tick_d = tick_inc;
        if (exp_setup) begin
          phase_d = PH_SP_B; scl_d = 1'b1; sda_d = 1'b0; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_SP_B: begin
        tick_d = tick_inc;
        if (exp_setup) begin
          phase_d = PH_SP_C; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_SP_C: begin
        tick_d = tick_inc;
        if (exp_setup) begin
          phase_d = PH_IDLE; tick_d = '0; done_d = 1'b1;
        end
      end
      PH_WR_LO: begin
        tick_d = tick_inc;
        if (exp_half) begin
          phase_d = PH_WR_HI; scl_d = 1'b1; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_WR_HI: begin
        tick_d = tick_inc;
        if (exp_half) begin
          phase_d = PH_WR_TL; scl_d = 1'b0; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_WR_TL: begin
        tick_d = tick_inc;
        if (exp_half) begin
          bit_d   = bit_inc;
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          tick_d  = '0;
          if (bit_inc < BitsPerByte) begin
            phase_d = PH_WR_LO; scl_d = 1'b0; sda_d = shift_q[ByteW-2]; oe_d = 1'b1;
          end else begin
            phase_d = PH_IDLE; done_d = 1'b1;
          end
        end
      end
      PH_WA_LO: begin
        tick_d = tick_inc;
        if (exp_half) begin
          wait_d  = '0;
          phase_d = PH_WA_HI; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b0; tick_d = '0;
        end
      end
      PH_WA_HI: begin
        if (!sda_in_i) begin
          err_d = 1'b0; scl_d = 1'b0;
          phase_d = PH_IDLE; tick_d = '0; done_d = 1'b1;
        end else if (wait_q >= tmo_q) begin
          // timed out: flag and release the bus with a stop
          err_d   = 1'b1;
          phase_d = PH_SP_A; scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1; tick_d = '0;
        end else begin
          wait_d = wait_q + 10'd1;
        end
      end
      PH_RD_LO: begin
        tick_d = tick_inc;
        if (exp_half) begin
          phase_d = PH_RD_HI; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b0; tick_d = '0;
        end
      end
      PH_RD_HI: begin
        tick_d = tick_inc;
        if (exp_half) begin
          shift_d = {shift_q[ByteW-2:0], sda_in_i};
          bit_d   = bit_inc;
          tick_d  = '0;
          if (bit_inc < BitsPerByte) begin
            phase_d = PH_RD_LO; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
          end else begin
            phase_d = PH_AK_LO; scl_d = 1'b0; sda_d = ~ack_q; oe_d = 1'b1;
          end
        end
      end
      PH_AK_LO: begin
        tick_d = tick_inc;
        if (exp_half) begin
          phase_d = PH_AK_HI; scl_d = 1'b1; oe_d = 1'b1; tick_d = '0;
        end
      end
      PH_AK_HI: begin
        tick_d = tick_inc;
        if (exp_half) begin
          scl_d = 1'b0; rx_d = shift_q;
          phase_d = PH_IDLE; tick_d = '0; done_d = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase

    res_d.scl_level  = scl_d;
    res_d.sda_level  = sda_d;
    res_d.sda_enable = oe_d;
    res_d.busy_res   = (phase_d != PH_IDLE);
    res_d.done_res   = done_d;
    res_d.rx_byte    = rx_d;
    res_d.ack_error  = err_d;
  end

  // Advance the sequencer on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      ack_q   <= 1'b0;
      err_q   <= 1'b0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b1;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      ack_q   <= ack_d;
      err_q   <= err_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
    end
  end

  // Output buffer control: skid entry drains into the output entry first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res_d;
      end
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = out_q.scl_level;
  assign sda_level_o  = out_q.sda_level;
  assign sda_enable_o = out_q.sda_enable;
  assign busy_res_o   = out_q.busy_res;
  assign done_res_o   = out_q.done_res;
  assign rx_byte_o    = out_q.rx_byte;
  assign ack_error_o  = out_q.ack_error;

endmodule

@@ hw/rtl/i2c_mbc_checker.sv @@
// Port-level assertions for the I2C master byte controller, with its bind.
module i2c_mbc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              scl_level_o,
  input logic                              sda_level_o,
  input logic                              sda_enable_o,
  input logic                              busy_res_o,
  input logic                              done_res_o,
  input logic [i2c_mbc_pkg::ByteW-1:0]     rx_byte_o,
  input logic                              ack_error_o
);
  import i2c_mbc_pkg::*;

  // Input is held back only while a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // After every accepted tick a result is valid in the next cycle
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result");

  // A completing command leaves the block idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("done reported while still busy");

  // A released SDA always shows a high level
  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sda_enable_o) |-> sda_level_o)
    else $error("sda released with low level");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(scl_level_o)
      && $stable(sda_level_o) && $stable(rx_byte_o) && $stable(ack_error_o)))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_controller i2c_mbc_checker u_i2c_mbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .scl_level_o  (scl_level_o),
  .sda_level_o  (sda_level_o),
  .sda_enable_o (sda_enable_o),
  .busy_res_o   (busy_res_o),
  .done_res_o   (done_res_o),
  .rx_byte_o    (rx_byte_o),
  .ack_error_o  (ack_error_o)
);
